/* rtl/core/cvm_pkg.sv */
// Package for the cell velocity moments block.
// Widths, constants and the command/status structs shared by all modules.
package cvm_pkg;

  localparam int unsigned VelW       = 24;
  localparam int unsigned MaxPerCell = 65536;
  localparam int unsigned CntW       = 17;
  localparam int unsigned SumW       = 40;
  localparam int unsigned SqW        = 64;
  localparam int unsigned ScaleW     = 32;
  localparam int unsigned TempW      = 32;
  localparam int unsigned DivW       = 64;
  localparam int unsigned ItW        = $clog2(DivW);
  localparam int unsigned NumComp    = 3;
  localparam int unsigned CompW      = 2;
  localparam int unsigned InDataW    = 3 * VelW;
  localparam int unsigned OutDataW   = 192;
  localparam int unsigned AddrW      = 3;

  localparam logic [ScaleW-1:0] TempScaleReset = ScaleW'(2067611);
  localparam logic [AddrW-1:0]  AddrTempScale  = AddrW'(0);

  typedef struct packed {
    logic             acc;
    logic             clear;
    logic             ld_mean_div;
    logic             st_mean;
    logic             div_step;
    logic             mul_m;
    logic             st_var;
    logic             mul_lo;
    logic             mul_hi;
    logic             st_temp;
    logic             out_load;
    logic [CompW-1:0] comp;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

/* rtl/core/cvm_ctrl.sv */
// Sequencer for the cell velocity moments block.
// Drives cvm_dp through cvm_pkg::cmd_t; uses cvm_pkg.
module cvm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  input  cvm_pkg::status_t status_i,
  output cvm_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    StAcc, StLdM, StDivM, StStM, StDivQ, StMulM, StVar, StMulL, StMulH, StTemp, StDone
  } state_e;

  state_e                      state_q;
  logic [cvm_pkg::CompW-1:0]   comp_q;
  logic [cvm_pkg::ItW-1:0]     it_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StAcc;
      comp_q  <= '0;
      it_q    <= '0;
    end else begin
      unique case (state_q)
        StAcc: begin
          comp_q <= '0;
          if (in_valid_i && in_last_i) state_q <= StLdM;
        end
        StLdM: begin
          it_q    <= '0;
          state_q <= StDivM;
        end
        StDivM: begin
          it_q <= it_q + 1'b1;
          if (it_q == '1) state_q <= StStM;
        end
        StStM: begin
          it_q    <= '0;
          state_q <= StDivQ;
        end
        StDivQ: begin
          it_q <= it_q + 1'b1;
          if (it_q == '1) state_q <= StMulM;
        end
        StMulM: state_q <= StVar;
        StVar:  state_q <= StMulL;
        StMulL: state_q <= StMulH;
        StMulH: state_q <= StTemp;
        StTemp: begin
          if (comp_q == cvm_pkg::CompW'(cvm_pkg::NumComp - 1)) begin
            state_q <= StDone;
          end else begin
            comp_q  <= comp_q + 1'b1;
            state_q <= StLdM;
          end
        end
        StDone: begin
          if (!status_i.out_busy) state_q <= StAcc;
        end
        default: state_q <= StAcc;
      endcase
    end
  end

  assign in_ready_o = (state_q == StAcc);

  always_comb begin
    cmd_o             = '0;
    cmd_o.comp        = comp_q;
    cmd_o.acc         = (state_q == StAcc) && in_valid_i;
    cmd_o.ld_mean_div = (state_q == StLdM);
    cmd_o.div_step    = (state_q == StDivM) || (state_q == StDivQ);
    cmd_o.st_mean     = (state_q == StStM);
    cmd_o.mul_m       = (state_q == StMulM);
    cmd_o.st_var      = (state_q == StVar);
    cmd_o.mul_lo      = (state_q == StMulL);
    cmd_o.mul_hi      = (state_q == StMulH);
    cmd_o.st_temp     = (state_q == StTemp);
    cmd_o.out_load    = (state_q == StDone) && !status_i.out_busy;
    cmd_o.clear       = cmd_o.out_load;
  end

endmodule

/* rtl/core/cvm_dp.sv */
// Datapath for the cell velocity moments block: accumulators, serial
// divider, multipliers and result registers. Uses cvm_pkg.
module cvm_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cvm_pkg::cmd_t                         cmd_i,
  output cvm_pkg::status_t                      status_o,
  input  logic [cvm_pkg::VelW-1:0]              vel_i [cvm_pkg::NumComp],
  input  logic [cvm_pkg::ScaleW-1:0]            temp_scale_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [cvm_pkg::VelW-1:0]              mean_o [cvm_pkg::NumComp],
  output logic [cvm_pkg::TempW-1:0]             temp_o [cvm_pkg::NumComp],
  output logic [cvm_pkg::CntW-1:0]              count_o
);

  localparam int unsigned VelW = cvm_pkg::VelW;
  localparam int unsigned CntW = cvm_pkg::CntW;
  localparam int unsigned SumW = cvm_pkg::SumW;
  localparam int unsigned SqW  = cvm_pkg::SqW;
  localparam int unsigned DivW = cvm_pkg::DivW;
  localparam int unsigned TW   = cvm_pkg::TempW;
  localparam logic [DivW-1:0] MeanMaxPos = DivW'(2 ** (VelW - 1) - 1);
  localparam logic [DivW-1:0] MeanMaxNeg = DivW'(2 ** (VelW - 1));

  logic [CntW-1:0]      count_q;
  logic signed [SumW-1:0] sum_q [cvm_pkg::NumComp];
  logic [SqW-1:0]       sumsq_q [cvm_pkg::NumComp];

  logic [DivW-1:0]      div_n_q;
  logic [CntW-1:0]      div_r_q;
  logic                 neg_q;
  logic [VelW-1:0]      mm_q;
  logic [VelW-1:0]      mean_q [cvm_pkg::NumComp];
  logic [TW-1:0]        temp_q [cvm_pkg::NumComp];
  logic [DivW-1:0]      q_q;
  logic [2*VelW-1:0]    msq_q;
  logic [SqW-1:0]       var_q;
  logic [63:0]          lo_q;
  logic [63:0]          hi_q;
  logic                 ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int c = 0; c < cvm_pkg::NumComp; c++) begin
        sum_q[c]   <= '0;
        sumsq_q[c] <= '0;
      end
    end else if (cmd_i.clear) begin
      count_q <= '0;
      for (int c = 0; c < cvm_pkg::NumComp; c++) begin
        sum_q[c]   <= '0;
        sumsq_q[c] <= '0;
      end
    end else if (cmd_i.acc && (count_q < CntW'(cvm_pkg::MaxPerCell))) begin
      count_q <= count_q + 1'b1;
      for (int c = 0; c < cvm_pkg::NumComp; c++) begin
        logic [VelW-1:0]   mag;
        logic [2*VelW-1:0] sq;
        logic [SqW:0]      acc2;
        mag        = vel_i[c][VelW-1] ? (~vel_i[c] + 1'b1) : vel_i[c];
        sq         = mag * mag;
        acc2       = {1'b0, sumsq_q[c]} + (SqW + 1)'(sq);
        sum_q[c]   <= sum_q[c] + SumW'($signed(vel_i[c]));
        sumsq_q[c] <= acc2[SqW] ? '1 : acc2[SqW-1:0];
      end
    end
  end

  logic signed [SumW-1:0] sel_sum;
  logic [SumW-1:0]        sel_mag;
  logic [CntW:0]          trial;
  logic                   ge;
  logic [DivW-1:0]        qmag;

  always_comb begin
    sel_sum = sum_q[cmd_i.comp];
    sel_mag = sel_sum[SumW-1] ? SumW'(-sel_sum) : SumW'(sel_sum);
    trial   = {div_r_q, div_n_q[DivW-1]};
    ge      = trial >= {1'b0, count_q};
    if (neg_q) qmag = (div_n_q > MeanMaxNeg) ? MeanMaxNeg : div_n_q;
    else       qmag = (div_n_q > MeanMaxPos) ? MeanMaxPos : div_n_q;
  end

  logic [64:0] up;
  logic [64:0] up_sh;
  always_comb begin
    up    = {1'b0, hi_q} + 65'(lo_q[63:32]) + 65'd128;
    up_sh = up >> 8;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_mean_div) begin
      div_n_q <= DivW'(sel_mag) + DivW'(count_q >> 1);
      div_r_q <= '0;
      neg_q   <= sel_sum[SumW-1];
    end else if (cmd_i.st_mean) begin
      mm_q               <= qmag[VelW-1:0];
      mean_q[cmd_i.comp] <= neg_q ? (~qmag[VelW-1:0] + 1'b1) : qmag[VelW-1:0];
      div_n_q            <= sumsq_q[cmd_i.comp];
      div_r_q            <= '0;
    end else if (cmd_i.div_step) begin
      div_r_q <= ge ? CntW'(trial - {1'b0, count_q}) : trial[CntW-1:0];
      div_n_q <= {div_n_q[DivW-2:0], ge};
    end
    if (cmd_i.mul_m) begin
      q_q   <= div_n_q;
      msq_q <= mm_q * mm_q;
    end
    if (cmd_i.st_var) var_q <= (q_q > SqW'(msq_q)) ? (q_q - SqW'(msq_q)) : '0;
    if (cmd_i.mul_lo) lo_q <= temp_scale_i * var_q[31:0];
    if (cmd_i.mul_hi) hi_q <= temp_scale_i * var_q[63:32];
    if (cmd_i.st_temp) begin
      if (hi_q[63] || (|up_sh[64:32])) temp_q[cmd_i.comp] <= '1;
      else                             temp_q[cmd_i.comp] <= up_sh[31:0];
    end
    if (cmd_i.out_load) begin
      mean_o  <= mean_q;
      temp_o  <= temp_q;
      count_o <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)              ovalid_q <= 1'b0;
    else if (cmd_i.out_load)  ovalid_q <= 1'b1;
    else if (out_ready_i)     ovalid_q <= 1'b0;
  end

  assign out_valid_o       = ovalid_q;
  assign status_o.out_busy = ovalid_q && !out_ready_i;

endmodule

/* rtl/core/cell_velocity_moments_core.sv */
// Cell velocity moments: one molecule velocity per request, one result per
// cell with mean velocity, temperature and molecule count. Accumulation takes
// a new molecule every clock while the sequencer is in its accumulate state.
// The closing molecule starts a sequence over the three components. Each
// component runs a load step, a 64-step run of the shared serial divider for
// the mean, a store step, a second 64-step run for the mean square and five
// multiply/finish steps. The result is loaded into the output register only
// when that register is free or its result is being taken, and input is
// taken again after that load. A finished result sits in the output register,
// so the next cell can accumulate while it waits. Uses cvm_pkg, cvm_ctrl and cvm_dp.
module cell_velocity_moments_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // vel_x, vel_y, vel_z
  input  logic [cvm_pkg::InDataW-1:0]       s_axis_tdata_i,
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // mean_x, mean_y, mean_z, temp_x, temp_y, temp_z, molecule_count, zero pad
  output logic [cvm_pkg::OutDataW-1:0]      m_axis_tdata_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cvm_pkg::AddrW-1:0]         paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int unsigned VelW = cvm_pkg::VelW;
  localparam int unsigned TW   = cvm_pkg::TempW;

  cvm_pkg::cmd_t               cmd;
  cvm_pkg::status_t            status;
  logic [cvm_pkg::ScaleW-1:0]  temp_scale_q;
  logic [VelW-1:0]             vel [cvm_pkg::NumComp];
  logic [VelW-1:0]             mean [cvm_pkg::NumComp];
  logic [TW-1:0]               temp [cvm_pkg::NumComp];
  logic [cvm_pkg::CntW-1:0]    count;

  assign pready = 1'b1;
  assign prdata = (paddr == cvm_pkg::AddrTempScale) ? temp_scale_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_scale_q <= cvm_pkg::TempScaleReset;
    end else if (psel && penable && pwrite && (paddr == cvm_pkg::AddrTempScale)) begin
      temp_scale_q <= pwdata;
    end
  end

  always_comb begin
    for (int c = 0; c < cvm_pkg::NumComp; c++) begin
      vel[c] = s_axis_tdata_i[c*VelW +: VelW];
    end
  end

  cvm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cvm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .vel_i        (vel),
    .temp_scale_i (temp_scale_q),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .mean_o       (mean),
    .temp_o       (temp),
    .count_o      (count)
  );

  assign m_axis_tdata_o = {
    (cvm_pkg::OutDataW - 3*VelW - 3*TW - cvm_pkg::CntW)'(0),
    count, temp[2], temp[1], temp[0], mean[2], mean[1], mean[0]
  };

`ifndef SYNTHESIS
  a_load_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> m_axis_tvalid_o) else $error("result load lost");
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("pending result overwritten");
  a_count_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (count != '0)) else $error("empty cell reported");
  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.acc |-> s_axis_tready_o) else $error("request taken while busy");
`endif

endmodule

/* verif/cell_velocity_moments_core_test.sv */
// Testbench for cell_velocity_moments_core: streams molecule velocities,
// predicts per-cell mean and temperature, and checks every result.
// Depends on cvm_pkg and the cell_velocity_moments_core RTL.
module cell_velocity_moments_core_test;

  typedef struct {
    logic signed [23:0] mean [3];
    logic [31:0]        temp [3];
    logic [16:0]        count;
  } cell_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  // vel_x, vel_y, vel_z
  logic [cvm_pkg::InDataW-1:0]   s_axis_tdata_i = '0;
  logic                          s_axis_tlast_i = 1'b0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  // mean_x, mean_y, mean_z, temp_x, temp_y, temp_z, molecule_count, zero pad
  logic [cvm_pkg::OutDataW-1:0]  m_axis_tdata_o;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [cvm_pkg::AddrW-1:0]     paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  cell_velocity_moments_core dut (.*);

  cell_result_t          cell_results_due [$];
  int unsigned           mol_count;
  longint                vel_sum [3];
  logic [63:0]           vel_sq_sum [3];
  logic [31:0]           scale_reg = cvm_pkg::TempScaleReset;
  int                    errors = 0;
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  int                    quiet_cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] temperature_of(logic [63:0] var_v, logic [31:0] scale);
    logic [127:0] prod;
    prod = 128'(var_v) * 128'(scale) + (128'd1 << 39);
    prod = prod >> 40;
    return (prod > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  task automatic accumulate_molecule(logic [23:0] v [3], logic last);
    cell_result_t r;
    longint signed sv;
    longint unsigned mag, q, msq, sq, mean_mag;
    logic [63:0] var_v;
    if (mol_count < cvm_pkg::MaxPerCell) begin
      for (int i = 0; i < 3; i++) begin
        sv = longint'($signed(v[i]));
        mag = sv < 0 ? -sv : sv;
        sq = mag * mag;
        vel_sum[i] += sv;
        if (vel_sq_sum[i] > ~64'd0 - sq) vel_sq_sum[i] = ~64'd0;
        else vel_sq_sum[i] += sq;
      end
      mol_count++;
    end
    if (!last) return;
    for (int i = 0; i < 3; i++) begin
      mag = vel_sum[i] < 0 ? -vel_sum[i] : vel_sum[i];
      mean_mag = (mag + mol_count / 2) / mol_count;
      if (vel_sum[i] < 0) begin
        if (mean_mag > 8388608) mean_mag = 8388608;
        r.mean[i] = 24'(-longint'(mean_mag));
      end else begin
        if (mean_mag > 8388607) mean_mag = 8388607;
        r.mean[i] = 24'(mean_mag);
      end
      msq = mean_mag * mean_mag;
      q = vel_sq_sum[i] / mol_count;
      var_v = q > msq ? q - msq : 64'd0;
      r.temp[i] = temperature_of(var_v, scale_reg);
      vel_sum[i] = 0;
      vel_sq_sum[i] = '0;
    end
    r.count = mol_count > 131071 ? 17'h1FFFF : 17'(mol_count);
    mol_count = 0;
    cell_results_due.push_back(r);
  endtask

  task automatic send_molecule(logic [23:0] vx, logic [23:0] vy, logic [23:0] vz,
                               logic last);
    logic [23:0] v [3];
    v[0] = vx; v[1] = vy; v[2] = vz;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {vz, vy, vx};
    s_axis_tlast_i <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    accumulate_molecule(v, last);
  endtask

  task automatic drop_valid();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    drop_valid();
    while (cell_results_due.size() != 0) @(posedge clk_i);
    repeat (450) @(posedge clk_i);
  endtask

  task automatic write_scale(logic [31:0] value);
    wait_drained();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= cvm_pkg::AddrTempScale; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    scale_reg = value;
  endtask

  function automatic logic [23:0] rand_vel();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      1: return 24'($signed($urandom_range(64)) - 32);
      2: return 24'($urandom_range(65535)) ^ {24{$urandom_range(1) == 1}};
      default: return 24'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      cell_result_t e;
      if (cell_results_due.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, m_axis_tdata_o);
        errors++;
      end else begin
        e = cell_results_due.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (m_axis_tdata_o[24*i +: 24] !== e.mean[i]) begin
            $display("%0t: mean[%0d] expected %h actual %h", $time, i, e.mean[i],
                     m_axis_tdata_o[24*i +: 24]);
            errors++;
          end
          if (m_axis_tdata_o[72 + 32*i +: 32] !== e.temp[i]) begin
            $display("%0t: temp[%0d] expected %h actual %h", $time, i, e.temp[i],
                     m_axis_tdata_o[72 + 32*i +: 32]);
            errors++;
          end
        end
        if (m_axis_tdata_o[168 +: 17] !== e.count) begin
          $display("%0t: count expected %0d actual %0d", $time, e.count,
                   m_axis_tdata_o[168 +: 17]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 40000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_directed();
    send_molecule(24'h7FFFFF, 24'h800000, 24'h000000, 1'b1);
    send_molecule(24'h000000, 24'h000000, 24'h000000, 1'b0);
    send_molecule(24'h000001, 24'hFFFFFF, 24'h000001, 1'b1);
    send_molecule(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0);
    send_molecule(24'h800000, 24'h7FFFFF, 24'h800000, 1'b1);
    send_molecule(24'h800000, 24'h800000, 24'h800000, 1'b0);
    send_molecule(24'h800000, 24'h800000, 24'h800000, 1'b0);
    send_molecule(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
    for (int i = 0; i < 6; i++)
      send_molecule(24'(i * 3), 24'(-i), 24'(i * 1000), i == 5);
    write_scale(32'hFFFF_FFFF);
    send_molecule(24'h7FFFFF, 24'h800000, 24'h001000, 1'b0);
    send_molecule(24'h800000, 24'h7FFFFF, 24'hFFF000, 1'b1);
    send_molecule(24'h000010, 24'h000020, 24'h000030, 1'b1);
    write_scale(32'h0);
    send_molecule(24'h7FFFFF, 24'h800000, 24'h123456, 1'b0);
    send_molecule(24'h800000, 24'h7FFFFF, 24'hABCDEF, 1'b1);
  endtask

  task automatic test_random_cells(int items);
    int sent;
    int cell_len;
    sent = 0;
    while (sent < items) begin
      cell_len = ($urandom_range(9) == 0) ? $urandom_range(200, 20) : $urandom_range(12, 1);
      if ($urandom_range(15) == 0) wait_drained();
      for (int k = 0; k < cell_len; k++)
        send_molecule(rand_vel(), rand_vel(), rand_vel(), k == cell_len - 1);
      sent += cell_len;
    end
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      vel_sum[i] = 0;
      vel_sq_sum[i] = '0;
    end
    mol_count = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 32; recv_idle_pct = 56;
    test_directed();
    write_scale(cvm_pkg::TempScaleReset);
    test_random_cells(500);
    write_scale($urandom);
    send_idle_pct = 56; recv_idle_pct = 32;
    test_random_cells(500);
    write_scale(32'hFFFF_FFFF);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_cells(250);
    write_scale(cvm_pkg::TempScaleReset);
    test_random_cells(250);
    wait_drained();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* cell_velocity_moments_core.f */
rtl/core/cvm_pkg.sv
rtl/core/cvm_ctrl.sv
rtl/core/cvm_dp.sv
rtl/core/cell_velocity_moments_core.sv
verif/cell_velocity_moments_core_test.sv
